/* rtl/bit_vector_range_engine_unit_defines.svh */
// Assertion macros for the bit vector range engine.
// Used by the port checker; needs nothing else.
`ifndef BIT_VECTOR_RANGE_ENGINE_UNIT_DEFINES_SVH
`define BIT_VECTOR_RANGE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge
`define BVRE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bit vector range engine: port check failed");

// Next-cycle implication, sampled on the rising clock edge
`define BVRE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bit vector range engine: port check failed");

`endif

/* rtl/bvre_pkg.sv */
// Shared constants, types and helper functions of the bit vector range engine.
// No dependencies; ctrl, byte unit, top and checker refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bvre_pkg;

   // Store geometry
   localparam int MaxBits    = 65536;
   localparam int ByteW      = 8;
   localparam int StoreBytes = (MaxBits + ByteW - 1) / ByteW;
   localparam int AddrW      = $clog2(StoreBytes);
   localparam int BitSelW    = $clog2(ByteW);

   // Field widths and bus packing
   localparam int FieldW    = 17;
   localparam int ModeW     = 2;
   localparam int ReqFieldW = 3 * FieldW + 1;
   localparam int ReqDataW  = ((ReqFieldW + 7) / 8) * 8;
   localparam int RspFieldW = FieldW + 2;
   localparam int RspDataW  = ((RspFieldW + 7) / 8) * 8;

   typedef enum logic [ModeW-1:0] {
      MODE_ASSIGN = 2'd0,
      MODE_TEST   = 2'd1,
      MODE_COUNT  = 2'd2,
      MODE_RESIZE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // One byte beat from the controller to the byte unit, aligned with read data
   typedef struct packed {
      logic             clr;   // clear the ones accumulator
      logic             vld;   // read data of this beat is on the RAM output
      logic             wr;    // write the merged byte back
      logic             fill;  // value written into masked bits
      logic [AddrW-1:0] addr;
      logic [ByteW-1:0] mask;
   } beat_type;

   // Bits lo..hi (inclusive) of a byte set
   function automatic logic [ByteW-1:0] span_mask(input logic [BitSelW-1:0] lo,
                                                  input logic [BitSelW-1:0] hi);
      logic [ByteW-1:0] m;
      for (int j = 0; j < ByteW; j++) begin
         m[j] = (BitSelW'(j) >= lo) && (BitSelW'(j) <= hi);
      end
      return m;
   endfunction

   // Number of ones in a byte
   function automatic logic [BitSelW:0] pop_byte(input logic [ByteW-1:0] b);
      logic [BitSelW:0] cnt;
      cnt = '0;
      for (int j = 0; j < ByteW; j++) begin
         cnt = cnt + (BitSelW + 1)'(b[j]);
      end
      return cnt;
   endfunction

endpackage

`default_nettype wire

/* rtl/bvre_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module bvre_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/bvre_byte_unit.sv */
// Byte datapath: merges the fill value into a read byte and counts masked ones.
// Depends on bvre_pkg; fed by bvre_ctrl, writes back into bvre_ram.
`timescale 1ns / 1ps
`default_nettype none

module bvre_byte_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bvre_pkg::beat_type            beat,
   input  wire logic [bvre_pkg::ByteW-1:0]    rd_data,
   output logic                               wr_en,
   output logic      [bvre_pkg::AddrW-1:0]    wr_addr,
   output logic      [bvre_pkg::ByteW-1:0]    wr_data,
   output logic      [bvre_pkg::FieldW-1:0]   ones
);

   logic [bvre_pkg::FieldW-1:0] ones_ff;
   logic [bvre_pkg::FieldW-1:0] ones_in;
   logic [bvre_pkg::ByteW-1:0]  hit;

   // Merge the fill value into the masked bits
   always_comb begin
      hit     = rd_data & beat.mask;
      wr_en   = beat.vld & beat.wr;
      wr_addr = beat.addr;
      wr_data = (rd_data & ~beat.mask) | (beat.fill ? beat.mask : '0);
   end

   // Ones accumulator over the beats of one item
   always_comb begin
      ones_in = ones_ff;
      if (beat.clr) begin
         ones_in = '0;
      end else if (beat.vld) begin
         ones_in = ones_ff + bvre_pkg::FieldW'(bvre_pkg::pop_byte(hit));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff <= '0;
      end else begin
         ones_ff <= ones_in;
      end
   end

   assign ones = ones_ff;

endmodule

`default_nettype wire

/* rtl/bvre_ctrl.sv */
// Sequencer: takes request beats, holds the length, walks the byte range through
// the RAM read port and forms the response. Depends on bvre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvre_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [bvre_pkg::ModeW-1:0]    req_mode,
   input  wire logic [bvre_pkg::FieldW-1:0]   req_first,
   input  wire logic [bvre_pkg::FieldW-1:0]   req_stop,
   input  wire logic                          req_value,
   input  wire logic [bvre_pkg::FieldW-1:0]   req_length,
   // response
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic                               rsp_bit,
   output logic      [bvre_pkg::FieldW-1:0]   rsp_tally,
   output logic                               rsp_error,
   // RAM read side and byte unit
   output logic                               rd_en,
   output logic      [bvre_pkg::AddrW-1:0]    rd_addr,
   output bvre_pkg::beat_type                 beat,
   input  wire logic [bvre_pkg::FieldW-1:0]   ones
);

   localparam int FieldW  = bvre_pkg::FieldW;
   localparam int AddrW   = bvre_pkg::AddrW;
   localparam int BitSelW = bvre_pkg::BitSelW;

   bvre_pkg::state_type state_ff, state_in;
   bvre_pkg::beat_type  beat_ff, beat_in;

   // control state
   logic [FieldW-1:0] len_ff, len_in;
   logic              rsp_vld_ff, rsp_vld_in;

   // latched command
   bvre_pkg::mode_type mode_ff, mode_in;
   logic [FieldW-1:0]  first_ff, first_in;
   logic [FieldW-1:0]  stop_ff, stop_in;
   logic               val_ff, val_in;
   logic [FieldW-1:0]  nlen_ff, nlen_in;

   // walk registers
   logic [AddrW-1:0]   addr_ff, addr_in;
   logic [AddrW-1:0]   head_ff, head_in;
   logic [AddrW-1:0]   tail_ff, tail_in;
   logic [BitSelW-1:0] lo_sel_ff, lo_sel_in;
   logic [BitSelW-1:0] hi_sel_ff, hi_sel_in;
   logic [FieldW-1:0]  span_ff, span_in;
   logic               err_ff, err_in;
   logic               wr_ff, wr_in;

   // response registers
   logic               rbit_ff, rbit_in;
   logic [FieldW-1:0]  tally_ff, tally_in;
   logic               rerr_ff, rerr_in;

   // range setup values
   logic [FieldW-1:0]  stop_c, nlen_s, lo, hi, hi_m1;
   logic               go, err_c, wr_c;
   logic               accept, prep_load, rsp_load;
   logic [BitSelW-1:0] lo_use, hi_use;

   // Range setup from the latched command
   always_comb begin
      stop_c = (stop_ff > len_ff) ? len_ff : stop_ff;
      nlen_s = (nlen_ff > FieldW'(bvre_pkg::MaxBits)) ? FieldW'(bvre_pkg::MaxBits) : nlen_ff;
      lo     = first_ff;
      hi     = stop_c;
      go     = 1'b0;
      err_c  = 1'b0;
      wr_c   = 1'b0;
      case (mode_ff)
         bvre_pkg::MODE_ASSIGN: begin
            go   = first_ff < stop_c;
            wr_c = 1'b1;
         end
         bvre_pkg::MODE_TEST: begin
            hi    = first_ff + FieldW'(1);
            go    = first_ff < len_ff;
            err_c = ~go;
         end
         bvre_pkg::MODE_COUNT: begin
            go    = first_ff < stop_c;
            err_c = first_ff > stop_c;
         end
         bvre_pkg::MODE_RESIZE: begin
            lo   = len_ff;
            hi   = nlen_s;
            go   = nlen_s > len_ff;
            wr_c = 1'b1;
         end
         default: begin
            go = 1'b0;
         end
      endcase
      hi_m1 = hi - FieldW'(1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bvre_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = bvre_pkg::ST_PREP;
         end
         bvre_pkg::ST_PREP: begin
            state_in = go ? bvre_pkg::ST_WALK : bvre_pkg::ST_FINISH;
         end
         bvre_pkg::ST_WALK: begin
            if (addr_ff == tail_ff) state_in = bvre_pkg::ST_DRAIN;
         end
         bvre_pkg::ST_DRAIN: begin
            state_in = bvre_pkg::ST_FINISH;
         end
         bvre_pkg::ST_FINISH: begin
            if (!rsp_vld_ff || rsp_tready) state_in = bvre_pkg::ST_IDLE;
         end
         default: begin
            state_in = bvre_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      prep_load  = 1'b0;
      rsp_load   = 1'b0;
      beat_in    = '0;
      lo_use     = (addr_ff == head_ff) ? lo_sel_ff : '0;
      hi_use     = (addr_ff == tail_ff) ? hi_sel_ff : '1;
      case (state_ff)
         bvre_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            beat_in.clr = req_tvalid;
         end
         bvre_pkg::ST_PREP: begin
            prep_load = 1'b1;
         end
         bvre_pkg::ST_WALK: begin
            rd_en        = 1'b1;
            beat_in.vld  = 1'b1;
            beat_in.wr   = wr_ff;
            beat_in.fill = val_ff;
            beat_in.addr = addr_ff;
            beat_in.mask = bvre_pkg::span_mask(lo_use, hi_use);
         end
         bvre_pkg::ST_DRAIN: begin
            rd_en = 1'b0;
         end
         bvre_pkg::ST_FINISH: begin
            rsp_load = !rsp_vld_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      accept = req_tready & req_tvalid;
   end

   // Register next values
   always_comb begin
      len_in     = len_ff;
      rsp_vld_in = rsp_vld_ff;
      mode_in    = mode_ff;
      first_in   = first_ff;
      stop_in    = stop_ff;
      val_in     = val_ff;
      nlen_in    = nlen_ff;
      addr_in    = addr_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      lo_sel_in  = lo_sel_ff;
      hi_sel_in  = hi_sel_ff;
      span_in    = span_ff;
      err_in     = err_ff;
      wr_in      = wr_ff;
      rbit_in    = rbit_ff;
      tally_in   = tally_ff;
      rerr_in    = rerr_ff;

      // latch the command beat
      if (accept) begin
         mode_in  = bvre_pkg::mode_type'(req_mode);
         first_in = req_first;
         stop_in  = req_stop;
         val_in   = req_value;
         nlen_in  = req_length;
      end

      // range setup, length update on resize
      if (prep_load) begin
         addr_in   = lo[BitSelW +: AddrW];
         head_in   = lo[BitSelW +: AddrW];
         tail_in   = hi_m1[BitSelW +: AddrW];
         lo_sel_in = lo[BitSelW-1:0];
         hi_sel_in = hi_m1[BitSelW-1:0];
         span_in   = stop_c - first_ff;
         err_in    = err_c;
         wr_in     = wr_c;
         if (mode_ff == bvre_pkg::MODE_RESIZE) len_in = nlen_s;
      end else if (state_ff == bvre_pkg::ST_WALK) begin
         addr_in = addr_ff + AddrW'(1);
      end

      // response output register
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
         rbit_in    = (mode_ff == bvre_pkg::MODE_TEST) && !err_ff && ones[0];
         rerr_in    = err_ff;
         tally_in   = '0;
         if (mode_ff == bvre_pkg::MODE_COUNT && !err_ff) begin
            tally_in = val_ff ? ones : span_ff - ones;
         end
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bvre_pkg::ST_IDLE;
         len_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         beat_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         rsp_vld_ff <= rsp_vld_in;
         beat_ff    <= beat_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      first_ff  <= first_in;
      stop_ff   <= stop_in;
      val_ff    <= val_in;
      nlen_ff   <= nlen_in;
      addr_ff   <= addr_in;
      head_ff   <= head_in;
      tail_ff   <= tail_in;
      lo_sel_ff <= lo_sel_in;
      hi_sel_ff <= hi_sel_in;
      span_ff   <= span_in;
      err_ff    <= err_in;
      wr_ff     <= wr_in;
      rbit_ff   <= rbit_in;
      tally_ff  <= tally_in;
      rerr_ff   <= rerr_in;
   end

   assign rd_addr    = addr_ff;
   assign beat       = beat_ff;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_bit    = rbit_ff;
   assign rsp_tally  = tally_ff;
   assign rsp_error  = rerr_ff;

endmodule

`default_nettype wire

/* rtl/bit_vector_range_engine_unit.sv */
// Channel  | Dir | Payload
// ---------+-----+---------------------------------------------------------------
// req_     | in  | tuser: mode; tdata: first_bit, stop_bit, bit_value, new_length
// rsp_     | out | tdata: bit_out, tally, error
//
// One item at a time. An item walks each store byte that it touches; test with a bad
// index, empty ranges and shrinks skip the walk.
// The walk moves one byte per cycle through the single read port of the byte RAM,
// with the merged byte written back in the cycle after its read.
// Reset clears the length to zero; the byte store is not cleared.
// The response register holds while rsp_tready is low; a new item may still be
// taken and then waits in its last step until the register frees up.
//
// Top level of the bit vector range engine. Depends on bvre_pkg, bvre_ram,
// bvre_byte_unit and bvre_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bit_vector_range_engine_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [16:0] first_bit, [33:17] stop_bit, [34] bit_value, [51:35] new_length
   input  wire logic [bvre_pkg::ReqDataW-1:0]   req_tdata,
   // [1:0] mode
   input  wire logic [bvre_pkg::ModeW-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] bit_out, [17:1] tally, [18] error
   output logic      [bvre_pkg::RspDataW-1:0]   rsp_tdata
);

   localparam int FieldW = bvre_pkg::FieldW;

   logic                       rd_en;
   logic [bvre_pkg::AddrW-1:0] rd_addr;
   logic [bvre_pkg::ByteW-1:0] rd_data;
   logic                       wr_en;
   logic [bvre_pkg::AddrW-1:0] wr_addr;
   logic [bvre_pkg::ByteW-1:0] wr_data;
   bvre_pkg::beat_type         beat;
   logic [FieldW-1:0]          ones;
   logic                       rsp_bit;
   logic [FieldW-1:0]          rsp_tally;
   logic                       rsp_error;

   // Sequencer
   bvre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_first  (req_tdata[0 +: FieldW]),
      .req_stop   (req_tdata[FieldW +: FieldW]),
      .req_value  (req_tdata[2*FieldW]),
      .req_length (req_tdata[2*FieldW+1 +: FieldW]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_bit    (rsp_bit),
      .rsp_tally  (rsp_tally),
      .rsp_error  (rsp_error),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .beat       (beat),
      .ones       (ones)
   );

   // Byte store
   bvre_ram #(
      .Width (bvre_pkg::ByteW),
      .Depth (bvre_pkg::StoreBytes)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Merge and count
   bvre_byte_unit u_byte (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .ones    (ones)
   );

   // Response packing
   assign rsp_tdata = {(bvre_pkg::RspDataW - bvre_pkg::RspFieldW)'(0),
                       rsp_error, rsp_tally, rsp_bit};

endmodule

`default_nettype wire

/* rtl/bvre_checker.sv */
// Port-level checks of the bit vector range engine, bound to the top level.
// Depends on bvre_pkg and bit_vector_range_engine_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "bit_vector_range_engine_unit_defines.svh"

module bvre_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [bvre_pkg::RspDataW-1:0] rsp_tdata
);

   logic [1:0] pend_ff, pend_in;
   logic       req_beat, rsp_beat;

   // Items taken but not yet answered
   always_comb begin
      req_beat = req_tvalid & req_tready;
      rsp_beat = rsp_tvalid & rsp_tready;
      pend_in  = pend_ff + 2'(req_beat) - 2'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // At most one item in work and one answer waiting
   `BVRE_ASSERT_IMP(a_pend_bound, clock, reset, 1'b1, pend_ff != 2'd3)
   // No answer without an item behind it
   `BVRE_ASSERT_IMP(a_rsp_has_item, clock, reset, rsp_tvalid, pend_ff != 2'd0)
   // Reset drops any pending answer
   `BVRE_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid)
   // A stalled answer holds its beat
   `BVRE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind bit_vector_range_engine_unit bvre_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* verif/bit_vector_range_engine_unit_test.sv */
// Self-checking testbench for bit_vector_range_engine_unit: directed and random
// assign, test, count and resize beats checked against an in-bench bit store mirror.
// Depends on bvre_pkg and the RTL of the bit vector range engine.
`timescale 1ns / 1ps

module bit_vector_range_engine_unit_test;
   import bvre_pkg::*;

   // Expected response of one request beat
   typedef struct packed {
      logic              bit_out;
      logic [FieldW-1:0] tally;
      logic              error;
   } verdict_type;

   // Mirror of the bit store and length; queues the response each request must produce
   class range_ledger;
      bit [ByteW-1:0] mirror [StoreBytes];
      int unsigned    cur_length;
      verdict_type    pending [$];
      int unsigned    per_mode [4];
      int unsigned    checked;
      int unsigned    failures;

      function void note_request(input mode_type m, input logic [FieldW-1:0] first,
                                 input logic [FieldW-1:0] stop, input logic val,
                                 input logic [FieldW-1:0] nlen);
         verdict_type v;
         int unsigned hi, ones, grow_to;
         v = '0;
         per_mode[int'(m)]++;
         // range end is clipped to the current length
         hi = (stop > cur_length) ? cur_length : stop;
         case (m)
            MODE_ASSIGN: begin
               for (int unsigned i = first; i < hi; i++) mirror[i / 8][i % 8] = val;
            end
            MODE_TEST: begin
               if (first >= cur_length) v.error = 1'b1;
               else v.bit_out = mirror[first / 8][first % 8];
            end
            MODE_COUNT: begin
               if (first > hi) begin
                  v.error = 1'b1;
               end else begin
                  ones = 0;
                  for (int unsigned i = first; i < hi; i++) ones += mirror[i / 8][i % 8];
                  v.tally = val ? FieldW'(ones) : FieldW'(hi - first - ones);
               end
            end
            default: begin
               // resize saturates at capacity; growth fills every added bit
               grow_to = (nlen > MaxBits) ? MaxBits : nlen;
               for (int unsigned i = cur_length; i < grow_to; i++) mirror[i / 8][i % 8] = val;
               cur_length = grow_to;
            end
         endcase
         pending.push_back(v);
      endfunction

      function void check_response(input logic b, input logic [FieldW-1:0] t,
                                   input logic e);
         verdict_type want;
         if (pending.size() == 0) begin
            $error("response beat with no request outstanding");
            failures++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (b !== want.bit_out) begin
            $error("bit_out: expected %0d, got %0d", want.bit_out, b);
            failures++;
         end
         if (t !== want.tally) begin
            $error("tally: expected %0d, got %0d", want.tally, t);
            failures++;
         end
         if (e !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, e);
            failures++;
         end
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic [ModeW-1:0]    req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [RspDataW-1:0] rsp_tdata;

   range_ledger ledger = new;
   logic        idle_on = 1'b0;
   int          stall_left = 0;

   bit_vector_range_engine_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short pauses, now and then a long one
   function automatic int pick_pause();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Response side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         if (stall_left == 0) rsp_tready <= 1'b1;
      end else if (idle_on && !reset && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = pick_pause();
      end
   end

   // Response monitor: [0] bit_out, [17:1] tally, [18] error
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_response(rsp_tdata[0], rsp_tdata[FieldW:1], rsp_tdata[FieldW+1]);
      end
   end

   // Present one request beat and hold it until accepted; entered and left at a falling edge
   task automatic issue_op(input mode_type m, input int unsigned first,
                           input int unsigned stop, input bit val, input int unsigned nlen);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_pause() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= m;
      req_tdata  <= ReqDataW'({nlen[FieldW-1:0], val, stop[FieldW-1:0], first[FieldW-1:0]});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      ledger.note_request(m, first[FieldW-1:0], stop[FieldW-1:0], val, nlen[FieldW-1:0]);
      @(negedge clock);
   endtask

   // One random phase: set a length, then mostly well-formed ranges with some noise
   task automatic run_phase(input bit big);
      int unsigned cur, a, b, nl;
      int          pick;
      mode_type    m;
      idle_on <= ($urandom_range(0, 3) != 0);
      nl = big ? $urandom_range(16384, 131071) : $urandom_range(0, 1024);
      issue_op(MODE_RESIZE, $urandom, $urandom, $urandom_range(0, 1), nl);
      repeat (39) begin
         cur  = ledger.cur_length;
         pick = $urandom_range(0, 99);
         m = (pick < 30) ? MODE_ASSIGN : (pick < 55) ? MODE_TEST :
             (pick < 85) ? MODE_COUNT : MODE_RESIZE;
         if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, 131071);
            b = $urandom_range(0, 131071);
         end else begin
            a = $urandom_range(0, cur);
            if ($urandom_range(0, 7) == 0) b = (a > 3) ? a - $urandom_range(1, 3) : 0;
            else b = a + $urandom_range(0, big ? 512 : 1040);
         end
         if (m == MODE_RESIZE) begin
            if (big) begin
               nl = cur + $urandom_range(0, 512);
               nl = (nl > 256) ? nl - 256 : 0;
            end else begin
               nl = $urandom_range(0, 1100);
            end
         end else begin
            nl = $urandom;
         end
         issue_op(m, a, b, $urandom_range(0, 1), nl);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty vector: test out of range, equal and reversed count, assign does nothing
      issue_op(MODE_TEST,   0, 0, 1'b0, 0);
      issue_op(MODE_COUNT,  0, 0, 1'b1, 0);
      issue_op(MODE_COUNT,  5, 10, 1'b0, 0);
      issue_op(MODE_ASSIGN, 0, 100, 1'b1, 0);
      // Oversized resize saturates at capacity, then full-range count and clipping
      issue_op(MODE_RESIZE, 0, 0, 1'b1, 131071);
      issue_op(MODE_COUNT,  0, 131071, 1'b1, 0);
      issue_op(MODE_ASSIGN, 3, 65533, 1'b0, 131071);
      issue_op(MODE_COUNT,  0, 65536, 1'b0, 0);
      issue_op(MODE_TEST,   0, 0, 1'b0, 0);
      issue_op(MODE_TEST,   65535, 0, 1'b0, 0);
      issue_op(MODE_TEST,   65536, 0, 1'b0, 0);
      issue_op(MODE_TEST,   131071, 131071, 1'b1, 131071);
      // Shrink, then grow across the partial byte so the next byte gets filled too
      issue_op(MODE_RESIZE, 0, 0, 1'b1, 13);
      issue_op(MODE_RESIZE, 0, 0, 1'b0, 40);
      issue_op(MODE_COUNT,  0, 40, 1'b1, 0);
      issue_op(MODE_TEST,   20, 0, 1'b0, 0);
      issue_op(MODE_TEST,   2, 0, 1'b0, 0);
      // Empty ranges: assign and count with equal bounds and with start past stop
      issue_op(MODE_ASSIGN, 10, 10, 1'b1, 0);
      issue_op(MODE_ASSIGN, 12, 9, 1'b1, 0);
      issue_op(MODE_COUNT,  30, 20, 1'b1, 0);
      issue_op(MODE_COUNT,  25, 25, 1'b0, 0);
      // Down to zero and back up with ones
      issue_op(MODE_RESIZE, 0, 0, 1'b1, 0);
      issue_op(MODE_RESIZE, 0, 0, 1'b1, 7);
      issue_op(MODE_TEST,   6, 0, 1'b0, 0);
      issue_op(MODE_COUNT,  0, 7, 1'b0, 0);

      // Random phases; every eighth one works on a long vector
      for (int p = 0; p < 50; p++) run_phase(p % 8 == 3);

      req_tvalid <= 1'b0;
      idle_on    <= 1'b0;
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Ran %0d assign, %0d test, %0d count and %0d resize beats;",
               ledger.per_mode[int'(MODE_ASSIGN)], ledger.per_mode[int'(MODE_TEST)],
               ledger.per_mode[int'(MODE_COUNT)], ledger.per_mode[int'(MODE_RESIZE)]);
      $display("%0d response beats compared, lengths up to full capacity.", ledger.checked);
      if (ledger.failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #50_000_000;
      $error("timeout with %0d responses outstanding", ledger.pending.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
